### hw/rtl/hpt_pkg.sv
// Shared constants for the homogeneous point transform.
// No dependencies; used by every other file of the block.
package hpt_pkg;
	localparam int NUM_REGS   = 8;
	localparam int REG_AW     = 3;
	localparam int PADDR_W    = 6;
	localparam int DATA_W     = 64;
	localparam int FIELD_W    = 32;
	localparam int MAG_W      = 64;
	localparam int ACC_W      = 67;

	typedef logic [DATA_W-1:0] cfg_word_t;
	typedef cfg_word_t cfg_bank_t [NUM_REGS];

	localparam cfg_bank_t CFG_RESET = '{
		64'h0000_0000_0001_0000, 64'h0,
		64'h0001_0000_0000_0000, 64'h0,
		64'h0,                   64'h0000_0000_0001_0000,
		64'h0,                   64'h0001_0000_0000_0000
	};
endpackage

### hw/rtl/hpt_if.sv
// Request channels of the point transform: input point and result.
// Depends on hpt_pkg for field widths.
interface hpt_point_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [hpt_pkg::FIELD_W-1:0]   in_x;
	logic signed [hpt_pkg::FIELD_W-1:0]   in_y;
	logic signed [hpt_pkg::FIELD_W-1:0]   in_z;
	modport source (output valid, in_x, in_y, in_z, input ready);
	modport sink   (input valid, in_x, in_y, in_z, output ready);
endinterface

interface hpt_result_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [hpt_pkg::FIELD_W-1:0]   out_x;
	logic signed [hpt_pkg::FIELD_W-1:0]   out_y;
	logic signed [hpt_pkg::FIELD_W-1:0]   out_z;
	logic                                 result_valid;
	logic                                 overflow;
	modport source (output valid, out_x, out_y, out_z, result_valid, overflow, input ready);
	modport sink   (input valid, out_x, out_y, out_z, result_valid, overflow, output ready);
endinterface

### hw/rtl/hpt_dot.sv
// One matrix row dot product: multiply stage, then sum and magnitude stage.
// Depends on hpt_pkg.
module hpt_dot #(
	parameter int FRAC_BITS   = 16,
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [hpt_pkg::DATA_W-1:0]    c01,
	input  logic [hpt_pkg::DATA_W-1:0]    c23,
	input  logic signed [COORD_WIDTH-1:0] x,
	input  logic signed [COORD_WIDTH-1:0] y,
	input  logic signed [COORD_WIDTH-1:0] z,
	output logic                          neg,
	output logic [hpt_pkg::MAG_W-1:0]     mag
);
	localparam int PW = 32 + COORD_WIDTH;

	logic signed [PW-1:0] px_s1, py_s1, pz_s1;
	logic signed [31:0]   t_s1;
	logic signed [hpt_pkg::ACC_W-1:0] sum, nsum;
	logic                             neg_s2;
	logic [hpt_pkg::MAG_W-1:0]        mag_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= $signed(c01[31:0]) * x;
			py_s1 <= $signed(c01[63:32]) * y;
			pz_s1 <= $signed(c23[31:0]) * z;
			t_s1  <= $signed(c23[63:32]);
		end
	end

	always_comb begin
		sum = hpt_pkg::ACC_W'(px_s1) + hpt_pkg::ACC_W'(py_s1) + hpt_pkg::ACC_W'(pz_s1)
			+ (hpt_pkg::ACC_W'(t_s1) <<< FRAC_BITS);
		nsum = -sum;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s2 <= sum[hpt_pkg::ACC_W-1];
			mag_s2 <= sum[hpt_pkg::ACC_W-1] ? nsum[hpt_pkg::MAG_W-1:0]
				: sum[hpt_pkg::MAG_W-1:0];
		end
	end

	assign neg = neg_s2;
	assign mag = mag_s2;
endmodule

### hw/rtl/hpt_div.sv
// Pipelined restoring divider, one quotient bit per stage, with saturation.
// Depends on hpt_pkg.
module hpt_div #(
	parameter int FRAC_BITS   = 16,
	parameter int COORD_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               en,
	input  logic                               an,
	input  logic [hpt_pkg::MAG_W-1:0]          am,
	input  logic                               wn,
	input  logic [hpt_pkg::MAG_W-1:0]          wm,
	output logic signed [hpt_pkg::FIELD_W-1:0] q,
	output logic                               ovf
);
	localparam int NW = hpt_pkg::MAG_W + FRAC_BITS;
	localparam int CW = COORD_WIDTH;

	logic [NW-1:0] num, hi;
	logic [hpt_pkg::MAG_W-1:0] rem_s [CW+1];
	logic [hpt_pkg::MAG_W-1:0] wm_s  [CW+1];
	logic [CW-1:0]             low_s [CW+1];
	logic [CW-1:0]             q_s   [CW+1];
	logic                      neg_s [CW+1];
	logic                      ovf_s [CW+1];

	always_comb begin
		num = {am, {FRAC_BITS{1'b0}}};
		hi  = num >> CW;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s[0] <= hi >= NW'(wm);
			rem_s[0] <= hi[hpt_pkg::MAG_W-1:0];
			low_s[0] <= num[CW-1:0];
			q_s[0]   <= '0;
			wm_s[0]  <= wm;
			neg_s[0] <= an ^ wn;
		end
	end

	for (genvar k = 0; k < CW; k++) begin : g_bit
		logic [hpt_pkg::MAG_W:0] trial, diff;
		logic                    ge;
		always_comb begin
			trial = {rem_s[k], low_s[k][CW-1]};
			diff  = trial - {1'b0, wm_s[k]};
			ge    = trial >= {1'b0, wm_s[k]};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? diff[hpt_pkg::MAG_W-1:0] : trial[hpt_pkg::MAG_W-1:0];
				q_s[k+1]   <= {q_s[k][CW-2:0], ge};
				low_s[k+1] <= low_s[k] << 1;
				wm_s[k+1]  <= wm_s[k];
				neg_s[k+1] <= neg_s[k];
				ovf_s[k+1] <= ovf_s[k];
			end
		end
	end

	logic [CW-1:0] lim, qm, qv;
	logic          sat;
	always_comb begin
		lim = neg_s[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
		sat = ovf_s[CW] || (q_s[CW] > lim);
		qm  = sat ? lim : q_s[CW];
		qv  = neg_s[CW] ? -qm : qm;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q   <= hpt_pkg::FIELD_W'($signed(qv));
			ovf <= sat;
		end
	end
endmodule

### hw/rtl/homogeneous_point_transform.sv
// Homogeneous 4x4 point transform with perspective divide.
// Pipeline of two dot stages, one divide setup stage, COORD_WIDTH
// quotient-bit stages and one saturate/output stage.
// Throughput one point per cycle; a stalled output holds the whole pipeline.
// Async active-low reset clears valid bits and loads the identity matrix.
module homogeneous_point_transform #(
	parameter int FRAC_BITS   = 16,
	parameter int COORD_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [hpt_pkg::PADDR_W-1:0]    paddr,
	input  logic [hpt_pkg::DATA_W-1:0]     pwdata,
	output logic [hpt_pkg::DATA_W-1:0]     prdata,
	output logic                           pready,
	hpt_point_if.sink                      in_pt,
	hpt_result_if.source                   out_pt
);
	localparam int LAT = COORD_WIDTH + 4;
	localparam int WZL = COORD_WIDTH + 2;

	hpt_pkg::cfg_bank_t cfg_q;
	logic [hpt_pkg::REG_AW-1:0] idx;
	logic en;
	logic [LAT-1:0] vld_q;
	logic [WZL-1:0] wz_q;
	logic signed [COORD_WIDTH-1:0] cx, cy, cz;
	logic [3:0] neg;
	logic [hpt_pkg::MAG_W-1:0] mag [4];
	logic signed [hpt_pkg::FIELD_W-1:0] qv [3];
	logic [2:0] ov;
	logic wz;

	assign idx    = paddr[hpt_pkg::PADDR_W-1:hpt_pkg::PADDR_W-hpt_pkg::REG_AW];
	assign pready = 1'b1;
	assign prdata = cfg_q[idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= hpt_pkg::CFG_RESET;
		end else if (psel && penable && pwrite) begin
			cfg_q[idx] <= pwdata;
		end
	end

	assign en          = !out_pt.valid || out_pt.ready;
	assign in_pt.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_pt.valid};
		end
	end

	assign cx = in_pt.in_x[COORD_WIDTH-1:0];
	assign cy = in_pt.in_y[COORD_WIDTH-1:0];
	assign cz = in_pt.in_z[COORD_WIDTH-1:0];

	for (genvar r = 0; r < 4; r++) begin : g_row
		hpt_dot #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH)) u_dot (
			.clk(clk), .en(en), .c01(cfg_q[2*r]), .c23(cfg_q[2*r+1]),
			.x(cx), .y(cy), .z(cz), .neg(neg[r]), .mag(mag[r])
		);
	end

	for (genvar l = 0; l < 3; l++) begin : g_lane
		hpt_div #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH)) u_div (
			.clk(clk), .en(en), .an(neg[l]), .am(mag[l]), .wn(neg[3]), .wm(mag[3]),
			.q(qv[l]), .ovf(ov[l])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wz_q <= {wz_q[WZL-2:0], mag[3] == '0};
		end
	end

	assign wz                  = wz_q[WZL-1];
	assign out_pt.valid        = vld_q[LAT-1];
	assign out_pt.out_x        = wz ? '0 : qv[0];
	assign out_pt.out_y        = wz ? '0 : qv[1];
	assign out_pt.out_z        = wz ? '0 : qv[2];
	assign out_pt.result_valid = !wz;
	assign out_pt.overflow     = !wz && (|ov);
endmodule
